// ----- hw/rtl/rtts_pkg.sv -----
package rtts_pkg;

  localparam int TABLE_DEPTH = 256;

  localparam logic FUNC_PIXEL       = 1'b0;
  localparam logic FUNC_TABLE_WRITE = 1'b1;

  // luminance weights in Q0.16, they sum to exactly 1.0
  localparam logic [15:0] LUM_W_RED   = 16'd13933;
  localparam logic [15:0] LUM_W_GREEN = 16'd46871;
  localparam logic [15:0] LUM_W_BLUE  = 16'd4732;

  // saturation gain in Q2.8
  localparam logic [9:0] GAIN_RESET = 10'd256;
  localparam logic [9:0] GAIN_MAX   = 10'd768;

  typedef struct packed {
    logic       func;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] table_index;
    logic [7:0] table_value;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pix_out_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

endpackage

// ----- hw/rtl/rtts_ram.sv -----
module rtts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/rtts_lum.sv -----
module rtts_lum (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  input  rtts_pkg::rgb_t up_rgb,
  output logic          up_ready,
  output logic          dn_valid,
  output rtts_pkg::rgb_t dn_rgb,
  output logic [23:0]   dn_lum,
  input  logic          dn_ready
);

  logic           valid_r;
  rtts_pkg::rgb_t rgb_r;
  logic [23:0]    lum_r;
  logic [23:0]    lum_nxt;
  logic [23:0]    prod_r_c;
  logic [23:0]    prod_g_c;
  logic [23:0]    prod_b_c;
  logic           adv;

  assign adv = !valid_r || dn_ready;
  assign up_ready = adv;

  // weights sum to 1.0, so the Q8.16 luminance never exceeds 24 bits
  assign prod_r_c = {8'd0, rtts_pkg::LUM_W_RED} * {16'd0, up_rgb.r};
  assign prod_g_c = {8'd0, rtts_pkg::LUM_W_GREEN} * {16'd0, up_rgb.g};
  assign prod_b_c = {8'd0, rtts_pkg::LUM_W_BLUE} * {16'd0, up_rgb.b};
  assign lum_nxt  = prod_r_c + prod_g_c + prod_b_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      rgb_r <= up_rgb;
      lum_r <= lum_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_rgb   = rgb_r;
  assign dn_lum   = lum_r;

endmodule

// ----- hw/rtl/rtts_sat.sv -----
module rtts_sat (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [9:0]        gain,
  input  logic              up_valid,
  input  rtts_pkg::rgb_t    up_rgb,
  input  logic [23:0]       up_lum,
  output logic              up_ready,
  output logic              dn_valid,
  output rtts_pkg::pix_out_t dn_data,
  input  logic              dn_ready
);

  function automatic logic signed [35:0] scale_diff(logic [7:0] c, logic [23:0] lum,
                                                    logic [9:0] g);
    logic signed [24:0] diff;
    diff = $signed({1'b0, c, 16'd0}) - $signed({1'b0, lum});
    return 36'(diff) * 36'($signed({1'b0, g}));
  endfunction

  // Q.24 value rounded half away from zero, clamped to 0..255
  function automatic logic [7:0] round_clamp(logic [23:0] lum, logic signed [35:0] prod);
    logic signed [35:0] sum;
    logic [35:0]        rnd;
    logic [11:0]        whole;
    sum   = $signed({4'd0, lum, 8'd0}) + prod;
    rnd   = $unsigned(sum) + 36'(1 << 23);
    whole = rnd[35:24];
    if (sum[35]) begin
      return 8'd0;
    end else if (whole > 12'd255) begin
      return 8'd255;
    end
    return whole[7:0];
  endfunction

  logic               s3_valid_r;
  logic [23:0]        s3_lum_r;
  logic signed [35:0] s3_prod_r_r;
  logic signed [35:0] s3_prod_g_r;
  logic signed [35:0] s3_prod_b_r;
  logic               s4_valid_r;
  rtts_pkg::pix_out_t s4_data_r;
  rtts_pkg::pix_out_t s4_data_nxt;
  logic               s3_adv;
  logic               s4_adv;

  assign s4_adv   = !s4_valid_r || dn_ready;
  assign s3_adv   = !s3_valid_r || s4_adv;
  assign up_ready = s3_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (s3_adv) begin
        s3_valid_r <= up_valid;
      end
      if (s4_adv) begin
        s4_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv && up_valid) begin
      s3_lum_r    <= up_lum;
      s3_prod_r_r <= scale_diff(up_rgb.r, up_lum, gain);
      s3_prod_g_r <= scale_diff(up_rgb.g, up_lum, gain);
      s3_prod_b_r <= scale_diff(up_rgb.b, up_lum, gain);
    end
  end

  always_comb begin
    s4_data_nxt.red_out   = round_clamp(s3_lum_r, s3_prod_r_r);
    s4_data_nxt.green_out = round_clamp(s3_lum_r, s3_prod_g_r);
    s4_data_nxt.blue_out  = round_clamp(s3_lum_r, s3_prod_b_r);
  end

  always_ff @(posedge clk) begin
    if (s4_adv && s3_valid_r) begin
      s4_data_r <= s4_data_nxt;
    end
  end

  assign dn_valid = s4_valid_r;
  assign dn_data  = s4_data_r;

endmodule

// ----- hw/rtl/rgb_tone_table_saturation.sv -----
// Per-pixel RGB888 adjuster: tone table lookup followed by saturation around
// the luminance.
// Input channel (in_valid / in_stall / in_data): each request is either a
// pixel (func = pixel) or a tone table write (func = table write). A table
// write stores table_value at table_index and gives no result; a pixel must
// only use table entries that were written since reset.
// Result channel (out_valid / out_stall / out_data): one result per pixel, in
// request order.
// Configuration (cfg_valid / cfg_ready / cfg_data): the Q2.8 saturation gain,
// 256 after reset, values above 768 act as 768. cfg_ready is always high;
// write it only while no pixel is in flight.
// Throughput: one request per clock while in_stall is low, set by a
// four-stage pipeline (table read, luminance, gain multiply, round and
// clamp); out_valid rises once a pixel's result is in the last stage.
// When out_stall is high each stage holds its data; empty stages still fill,
// so up to four pixels are held before in_stall rises.
// Reset empties the pipeline and restores the gain; the tone table keeps
// whatever it held and must be reloaded.
module rgb_tone_table_saturation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rtts_pkg::pix_in_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rtts_pkg::pix_out_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [9:0]         cfg_data
);

  logic [9:0]     gain_r;
  logic [9:0]     gain_eff;
  logic           s1_valid_r;
  logic           s1_adv;
  logic           in_accept;
  logic           tbl_we;
  logic           px_req;
  rtts_pkg::rgb_t s1_rgb;
  logic           lum_ready;
  logic           lum_valid;
  rtts_pkg::rgb_t lum_rgb;
  logic [23:0]    lum_val;
  logic           sat_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= rtts_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gain_r <= cfg_data;
    end
  end

  assign gain_eff = (gain_r > rtts_pkg::GAIN_MAX) ? rtts_pkg::GAIN_MAX : gain_r;

  assign s1_adv    = !s1_valid_r || lum_ready;
  assign in_stall  = !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign tbl_we    = in_accept && (in_data.func == rtts_pkg::FUNC_TABLE_WRITE);
  assign px_req    = in_accept && (in_data.func == rtts_pkg::FUNC_PIXEL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= px_req;
    end
  end

  // one table copy per channel so all three lookups happen in the same cycle
  rtts_ram #(.WIDTH(8), .DEPTH(rtts_pkg::TABLE_DEPTH)) u_tbl_red (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (in_data.table_index),
    .wdata (in_data.table_value),
    .re    (px_req),
    .raddr (in_data.red_in),
    .rdata (s1_rgb.r)
  );

  rtts_ram #(.WIDTH(8), .DEPTH(rtts_pkg::TABLE_DEPTH)) u_tbl_green (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (in_data.table_index),
    .wdata (in_data.table_value),
    .re    (px_req),
    .raddr (in_data.green_in),
    .rdata (s1_rgb.g)
  );

  rtts_ram #(.WIDTH(8), .DEPTH(rtts_pkg::TABLE_DEPTH)) u_tbl_blue (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (in_data.table_index),
    .wdata (in_data.table_value),
    .re    (px_req),
    .raddr (in_data.blue_in),
    .rdata (s1_rgb.b)
  );

  rtts_lum u_lum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid_r),
    .up_rgb   (s1_rgb),
    .up_ready (lum_ready),
    .dn_valid (lum_valid),
    .dn_rgb   (lum_rgb),
    .dn_lum   (lum_val),
    .dn_ready (sat_ready)
  );

  rtts_sat u_sat (
    .clk      (clk),
    .rst_n    (rst_n),
    .gain     (gain_eff),
    .up_valid (lum_valid),
    .up_rgb   (lum_rgb),
    .up_lum   (lum_val),
    .up_ready (sat_ready),
    .dn_valid (out_valid),
    .dn_data  (out_data),
    .dn_ready (!out_stall)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam logic [9:0] GAIN_UNITY = 10'd256;
  localparam int PHASE_REQS = 108;
  localparam int NUM_PHASES = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  rtts_pkg::pix_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rtts_pkg::pix_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [9:0] cfg_data = rtts_pkg::GAIN_RESET;

  rgb_tone_table_saturation u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state, updated as requests are accepted
  logic [7:0] tone_copy [rtts_pkg::TABLE_DEPTH];
  logic [9:0] gain_copy = rtts_pkg::GAIN_RESET;
  rtts_pkg::pix_out_t expected_pixels [$];

  // generator view of which table entries already hold data
  rtts_pkg::pix_in_t pending_reqs [$];
  bit gen_written [rtts_pkg::TABLE_DEPTH];
  logic [7:0] gen_pool [$];
  logic [7:0] last_written = '0;

  int errors = 0;
  int pixels_checked = 0;
  int table_writes = 0;
  int gain_writes = 0;
  bit calm = 1'b0;

  int in_gap = 0;
  int in_window = 0;
  int in_pct = 0;
  int out_burst = 0;
  int out_window = 0;
  int out_pct = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  int gain_steps [NUM_PHASES] = '{0, 768, 1023, 255, 257, 512, 769, 128, 384, 256};

  function automatic logic [7:0] round_clamp(longint acc);
    longint r;
    if (acc < 0) begin
      return 8'd0;
    end
    r = (acc + (longint'(1) << 23)) >>> 24;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  function automatic rtts_pkg::pix_out_t adjust_pixel(rtts_pkg::pix_in_t req);
    int ch [3];
    logic [7:0] res [3];
    longint lum, diff, acc;
    logic [9:0] g;
    rtts_pkg::pix_out_t pix;
    ch[0] = int'(tone_copy[req.red_in]);
    ch[1] = int'(tone_copy[req.green_in]);
    ch[2] = int'(tone_copy[req.blue_in]);
    g = (gain_copy > rtts_pkg::GAIN_MAX) ? rtts_pkg::GAIN_MAX : gain_copy;
    if (g == GAIN_UNITY) begin
      for (int i = 0; i < 3; i++) res[i] = ch[i][7:0];
    end else begin
      lum = longint'(rtts_pkg::LUM_W_RED) * ch[0] + longint'(rtts_pkg::LUM_W_GREEN) * ch[1]
          + longint'(rtts_pkg::LUM_W_BLUE) * ch[2];
      for (int i = 0; i < 3; i++) begin
        diff = (longint'(ch[i]) << 16) - lum;
        acc = (lum << 8) + diff * longint'(g);
        res[i] = round_clamp(acc);
      end
    end
    pix.red_out = res[0];
    pix.green_out = res[1];
    pix.blue_out = res[2];
    return pix;
  endfunction

  task automatic push_write(logic [7:0] idx, logic [7:0] val);
    rtts_pkg::pix_in_t req;
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    req = noise[$bits(rtts_pkg::pix_in_t)-1:0];
    req.func = rtts_pkg::FUNC_TABLE_WRITE;
    req.table_index = idx;
    req.table_value = val;
    if (!gen_written[idx]) begin
      gen_written[idx] = 1'b1;
      gen_pool.push_back(idx);
    end
    last_written = idx;
    pending_reqs.push_back(req);
  endtask

  task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    rtts_pkg::pix_in_t req;
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    req = noise[$bits(rtts_pkg::pix_in_t)-1:0];
    req.func = rtts_pkg::FUNC_PIXEL;
    req.red_in = r;
    req.green_in = g;
    req.blue_in = b;
    pending_reqs.push_back(req);
  endtask

  // pixels only index entries that were written before them
  task automatic push_random(int write_pct);
    logic [7:0] c [3];
    if ($urandom_range(99) < write_pct) begin
      push_write(8'($urandom), 8'($urandom));
    end else begin
      for (int i = 0; i < 3; i++) c[i] = gen_pool[$urandom_range(gen_pool.size() - 1)];
      if ($urandom_range(4) == 0) c[$urandom_range(2)] = last_written;
      push_pixel(c[0], c[1], c[2]);
    end
  endtask

  task automatic write_gain(logic [9:0] g);
    @(posedge clk);
    cfg_data <= g;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gain_copy = g;
    gain_writes++;
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_pixels.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic check_channel(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result(rtts_pkg::pix_out_t got);
    rtts_pkg::pix_out_t want;
    if (expected_pixels.size() == 0) begin
      errors++;
      $display("%0t: result %h with none expected", $time, got);
    end else begin
      want = expected_pixels.pop_front();
      pixels_checked++;
      check_channel("red_out", want.red_out, got.red_out);
      check_channel("green_out", want.green_out, got.green_out);
      check_channel("blue_out", want.blue_out, got.blue_out);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (in_data.func == rtts_pkg::FUNC_TABLE_WRITE) begin
          tone_copy[in_data.table_index] = in_data.table_value;
          table_writes++;
        end else begin
          expected_pixels.push_back(adjust_pixel(in_data));
        end
      end
      if (in_window == 0) begin
        in_window = 50;
        in_pct = calm ? 0 : 20 * $urandom_range(0, 2);
      end else begin
        in_window--;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          if (!calm && $urandom_range(99) < in_pct) begin
            in_gap = $urandom_range(0, 5);
            in_valid <= 1'b0;
          end else begin
            in_data <= pending_reqs.pop_front();
            in_valid <= 1'b1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_result(out_data);
      end
      if (out_window == 0) begin
        out_window = 50;
        out_pct = calm ? 0 : 20 * $urandom_range(0, 2);
      end else begin
        out_window--;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && pixels_checked >= 200) begin
        // long hold so the pipeline fills and pushes back on requests
        hold_done = 1'b1;
        hold_left = 79;
        out_stall <= 1'b1;
      end else if (out_burst != 0) begin
        out_burst--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(99) < out_pct) begin
        out_burst = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests at reset gain (unity)
    push_write(8'd0, 8'd255);
    push_write(8'd255, 8'd0);
    push_write(8'd128, 8'd128);
    push_write(8'd1, 8'd1);
    push_write(8'd254, 8'd254);
    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd0, 8'd255, 8'd128);
    push_pixel(8'd1, 8'd254, 8'd0);
    // overwrite then read back right away
    push_write(8'd0, 8'd0);
    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd0, 8'd255, 8'd0);
    push_write(8'd170, 8'd85);
    push_write(8'd85, 8'd170);
    push_pixel(8'd170, 8'd85, 8'd170);
    push_write(8'd255, 8'd255);
    push_pixel(8'd255, 8'd0, 8'd255);
    push_pixel(8'd0, 8'd0, 8'd255);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_gain(10'(gain_steps[ph]));
      if (ph == NUM_PHASES - 1) calm = 1'b1;
      repeat (PHASE_REQS) push_random((ph == 0) ? 50 : 30);
      drain();
    end

    errors += expected_pixels.size();
    $display("checked %0d pixels with %0d tone table writes", pixels_checked, table_writes);
    $display("across %0d saturation gain settings", gain_writes + 1);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
